[hdl/llba_pkg.sv]
// Package for the least-loaded bin assigner: field widths, register codes and
// the control word passed from the register block to the core. No dependencies.
package llba_pkg;

	localparam int LOAD_W   = 48;
	localparam int WEIGHT_W = 32;
	localparam int COUNT_W  = 5;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 3;

	localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

	localparam logic REG_BIN_COUNT = 1'b0;

	localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = COUNT_W'(1);

	typedef struct packed {
		logic               clear;
		logic [COUNT_W-1:0] bin_count;
	} cfg_ctl_t;

endpackage

[hdl/llba_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; used for every memory of the bin assigner.
module llba_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/llba_cfg.sv]
// APB register block of the bin assigner: holds bin_count and flags a clear of
// all bin loads on every write to it. Depends on llba_pkg.
module llba_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [llba_pkg::PADDR_W-1:0]   paddr,
	input  logic [llba_pkg::DATA_W-1:0]    pwdata,
	output logic [llba_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output llba_pkg::cfg_ctl_t             cfg_ctl
);

	import llba_pkg::*;

	logic               wr_count;
	logic [COUNT_W-1:0] bin_count_q;

	assign pready   = 1'b1;
	assign wr_count = psel && penable && pwrite && (paddr[2] == REG_BIN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= BIN_COUNT_RESET;
		end else if (wr_count) begin
			bin_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BIN_COUNT) begin
			prdata = {{(DATA_W-COUNT_W){1'b0}}, bin_count_q};
		end
	end

	assign cfg_ctl.clear     = wr_count;
	assign cfg_ctl.bin_count = bin_count_q;

endmodule

[hdl/llba_core.sv]
// Sequencer of the bin assigner: reads the sorted loads from the RAM, adds the
// job to the first bin and walks it back into order. Depends on llba_pkg, llba_ram.
module llba_core #(
	parameter int MAX_BINS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  llba_pkg::cfg_ctl_t              cfg_ctl,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [llba_pkg::WEIGHT_W-1:0]   job_weight,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [llba_pkg::LOAD_W-1:0]     assigned_load,
	output logic [llba_pkg::LOAD_W-1:0]     max_load,
	output logic                            saturated
);

	import llba_pkg::*;

	localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    last;
	logic [WEIGHT_W-1:0] weight_q;
	logic [LOAD_W-1:0]   sum_q;
	logic                sat_q;
	logic [LOAD_W-1:0]   max_q;
	logic [MAX_BINS-1:0] valid_q;
	logic                out_valid_q;
	logic [LOAD_W-1:0]   out_load_q;
	logic [LOAD_W-1:0]   out_max_q;
	logic                out_sat_q;

	logic                accept;
	logic                out_free;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [LOAD_W-1:0]   rd_data;
	logic [LOAD_W-1:0]   rd_load;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [LOAD_W-1:0]   wr_data;
	logic [LOAD_W:0]     sum_ext;
	logic [LOAD_W-1:0]   new_max;

	always_comb begin
		if (cfg_ctl.bin_count == '0) begin
			last = '0;
		end else if (int'(cfg_ctl.bin_count) > MAX_BINS) begin
			last = IDX_W'(MAX_BINS - 1);
		end else begin
			last = IDX_W'(cfg_ctl.bin_count - COUNT_W'(1));
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign rd_load = valid_q[idx_q] ? rd_data : '0;
	assign sum_ext = {1'b0, rd_load} + {{(LOAD_W+1-WEIGHT_W){1'b0}}, weight_q};
	assign new_max = (sum_q > max_q) ? sum_q : max_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = sum_q;
		case (state_q)
			ST_IDLE: begin
				rd_en   = accept;
				rd_addr = '0;
			end
			ST_LOAD: begin
				rd_en   = (last != '0);
				rd_addr = IDX_W'(1);
			end
			ST_SCAN: begin
				wr_en   = 1'b1;
				wr_addr = idx_q - IDX_W'(1);
				wr_data = (rd_load <= sum_q) ? rd_load : sum_q;
				rd_en   = (rd_load <= sum_q) && (idx_q != last);
				rd_addr = idx_q + IDX_W'(1);
			end
			ST_FIN: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = sum_q;
			end
			default: begin
			end
		endcase
	end

	llba_ram #(
		.WIDTH(LOAD_W),
		.DEPTH(MAX_BINS)
	) u_loads (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			valid_q     <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_ctl.clear) begin
				valid_q <= '0;
				max_q   <= '0;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (restart) begin
							valid_q <= '0;
							max_q   <= '0;
						end
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (last == '0) begin
						idx_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						idx_q   <= IDX_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_load > sum_q) begin
						state_q <= ST_DONE;
					end else if (idx_q == last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						max_q       <= new_max;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			weight_q <= job_weight;
		end
		if (state_q == ST_LOAD) begin
			sum_q <= sum_ext[LOAD_W] ? LOAD_MAX : sum_ext[LOAD_W-1:0];
			sat_q <= sum_ext[LOAD_W];
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_load_q <= sum_q;
			out_max_q  <= new_max;
			out_sat_q  <= sat_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign assigned_load = out_load_q;
	assign max_load      = out_max_q;
	assign saturated     = out_sat_q;

endmodule

[hdl/least_loaded_bin_assigner_top.sv]
// Top level of the least-loaded bin assigner: ties the APB register block to
// the RAM-based sequencer. Depends on llba_pkg, llba_cfg, llba_core.
// With N bins in use a job word walks through at most N loads of the load RAM, and its
// result word appears once that walk has finished; no new job is taken meanwhile.
// A stalled result holds the next job back only once that job's walk has finished.
// Reset sets bin_count to one and marks every load as zero; no clearing pass.
module least_loaded_bin_assigner_top #(
	parameter int MAX_BINS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [llba_pkg::PADDR_W-1:0]    paddr,
	input  logic [llba_pkg::DATA_W-1:0]     pwdata,
	output logic [llba_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [llba_pkg::WEIGHT_W-1:0]   job_weight,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [llba_pkg::LOAD_W-1:0]     assigned_load,
	output logic [llba_pkg::LOAD_W-1:0]     max_load,
	output logic                            saturated
);

	import llba_pkg::*;

	cfg_ctl_t cfg_ctl;

	llba_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg_ctl(cfg_ctl)
	);

	llba_core #(
		.MAX_BINS(MAX_BINS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_ctl      (cfg_ctl),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.job_weight   (job_weight),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.assigned_load(assigned_load),
		.max_load     (max_load),
		.saturated    (saturated)
	);

endmodule

[hdl/llba_checker.sv]
// Port-level checks for the least-loaded bin assigner, bound to the top level.
// Depends on llba_pkg and least_loaded_bin_assigner_top.
module llba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [llba_pkg::LOAD_W-1:0]   assigned_load,
	input logic [llba_pkg::LOAD_W-1:0]   max_load,
	input logic                          saturated
);

	import llba_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(assigned_load) && $stable(max_load))
		else $error("result word changed while stalled");

	a_max_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> max_load >= assigned_load)
		else $error("maximum load below assigned load");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> assigned_load == LOAD_MAX)
		else $error("saturated load not at full scale");

	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second job taken before the walk finished");

endmodule

bind least_loaded_bin_assigner_top llba_checker u_llba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.assigned_load(assigned_load),
	.max_load     (max_load),
	.saturated    (saturated)
);
